// File: rtl/core/ft12_frame_receiver_assert.svh
// ============================================================================
// ft12_frame_receiver_assert.svh
// Assertion macros shared by the FT1.2 receiver checkers.
// ============================================================================
`ifndef FT12_FRAME_RECEIVER_ASSERT_SVH
`define FT12_FRAME_RECEIVER_ASSERT_SVH

// antecedent implies consequent in the same cycle, ignored during reset
`define FT12_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("ft12 receiver: same-cycle check failed");

// antecedent implies consequent in the next cycle, ignored during reset
`define FT12_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("ft12 receiver: next-cycle check failed");

// consequent in the next cycle, checked through reset as well
`define FT12_ASSERT_ALWAYS_NEXT(label, clk_s, ante, cons) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("ft12 receiver: reset behaviour check failed");

`endif

// File: rtl/core/ft12_pkg.sv
// ============================================================================
// ft12_pkg
// Types and constants for the FT1.2 variable-frame receiver.
// ============================================================================
package ft12_pkg;

  localparam int HEADER_BYTES = 11;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [31:0] WORD0_MASK = 32'hffff_ff00;

  // transaction kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_CHAR  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

  localparam logic [7:0]  START_CHAR_RST = 8'h68;
  localparam logic [7:0]  STOP_CHAR_RST  = 8'h16;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd100;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        word_write;
    logic [6:0]  word_index;
    logic [31:0] word_value;
    logic        frame_good;
    logic [7:0]  link_control;
    logic [7:0]  dest_subaddress;
    logic [15:0] message_type;
    logic [15:0] dest_address;
    logic [15:0] source_address;
    logic [7:0]  hop_count;
    logic [15:0] sequence_number;
    logic        buffer_full;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_char;
    logic [7:0]  stop_char;
    logic [15:0] idle_limit;
  } cfg_regs_t;

endpackage

// File: rtl/core/ft12_out_queue.sv
// ============================================================================
// ft12_out_queue
// Two-entry result queue; decouples the receive path from downstream stalls.
// ============================================================================
module ft12_out_queue
  import ft12_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t  entry_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/ft12_rx_core.sv
// ============================================================================
// ft12_rx_core
// Frame hunt, byte counting, checksum, header capture and word packing.
// ============================================================================
module ft12_rx_core
  import ft12_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  logic [31:0] shift_r,    shift_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [8:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  len_r,      len_nxt;
  logic [7:0]  sum_r,      sum_nxt;
  logic [31:0] asm_r,      asm_nxt;
  logic [1:0]  lane_r,     lane_nxt;
  logic [6:0]  ptr_r,      ptr_nxt;
  logic [15:0] idle_r,     idle_nxt;
  logic        full_r,     full_nxt;
  logic [7:0]  hdr_r   [HEADER_BYTES];
  logic [7:0]  hdr_nxt [HEADER_BYTES];

  logic [7:0]  b;
  logic [31:0] shift_cat;
  logic [8:0]  n;
  logic [8:0]  total;
  logic        last;
  logic [31:0] asm_byte;
  logic [16:0] idle_inc;

  assign b         = item.rx_byte;
  assign shift_cat = {shift_r[23:0], b};
  assign n         = byte_cnt_r + 9'd1;
  assign total     = {1'b0, len_r} + 9'd2;
  assign last      = (n >= total);
  assign asm_byte  = {24'd0, b} << {lane_r, 3'b000};
  assign idle_inc  = {1'b0, idle_r} + 17'd1;

  always_comb begin
    shift_nxt    = shift_r;
    in_frame_nxt = in_frame_r;
    byte_cnt_nxt = byte_cnt_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    asm_nxt      = asm_r;
    lane_nxt     = lane_r;
    ptr_nxt      = ptr_r;
    idle_nxt     = idle_r;
    full_nxt     = full_r;
    hdr_nxt      = hdr_r;
    result       = '0;

    unique case (item.kind)
      KIND_BYTE: begin
        if (!full_r) begin
          idle_nxt = 16'd0;
          if (!in_frame_r) begin
            shift_nxt = shift_cat;
            // start, L, L, start with the newest byte in the low lane
            if (shift_cat[7:0] == cfg.start_char && shift_cat[31:24] == cfg.start_char &&
                shift_cat[15:8] == shift_cat[23:16]) begin
              len_nxt           = shift_cat[15:8];
              in_frame_nxt      = 1'b1;
              byte_cnt_nxt      = 9'd0;
              sum_nxt           = 8'd0;
              result.word_write = 1'b1;
              result.word_index = 7'd0;
              result.word_value = {shift_cat[15:8], shift_cat[15:8], cfg.start_char, 8'h00}
                                  & WORD0_MASK;
              asm_nxt           = {24'd0, cfg.start_char};
              lane_nxt          = 2'd1;
              ptr_nxt           = 7'd1;
              shift_nxt         = 32'd0;
            end
          end else begin
            byte_cnt_nxt = n;
            if (n <= {1'b0, len_r}) begin
              sum_nxt = sum_r + b;
            end else if (n == {1'b0, len_r} + 9'd1) begin
              sum_nxt = sum_r ^ b;  // zero when checksum matches
            end
            for (int i = 0; i < HEADER_BYTES; i++) begin
              if (n == 9'(i + 1)) begin
                hdr_nxt[i] = b;
              end
            end
            asm_nxt = (lane_r == 2'd0) ? {24'd0, b} : (asm_r | asm_byte);
            if (lane_r == 2'd3 || last) begin
              result.word_write = 1'b1;
              result.word_index = ptr_r;
              result.word_value = asm_nxt;
            end
            if (lane_r == 2'd3) begin
              lane_nxt = 2'd0;
              ptr_nxt  = ptr_r + 7'd1;
            end else begin
              lane_nxt = lane_r + 2'd1;
            end
            if (last) begin
              in_frame_nxt = 1'b0;
              if (sum_nxt == 8'd0 && b == cfg.stop_char) begin
                full_nxt          = 1'b1;
                result.frame_good = 1'b1;
              end
            end
          end
        end
      end
      KIND_TICK: begin
        if (idle_inc > {1'b0, cfg.idle_limit}) begin
          idle_nxt     = 16'd0;
          in_frame_nxt = 1'b0;
        end else begin
          idle_nxt = idle_inc[15:0];
        end
      end
      KIND_RELEASE: begin
        full_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    result.link_control    = hdr_nxt[0];
    result.dest_subaddress = hdr_nxt[1];
    result.message_type    = {hdr_nxt[3], hdr_nxt[2]};
    result.dest_address    = {hdr_nxt[5], hdr_nxt[4]};
    result.source_address  = {hdr_nxt[7], hdr_nxt[6]};
    result.hop_count       = hdr_nxt[8];
    result.sequence_number = {hdr_nxt[10], hdr_nxt[9]};
    result.buffer_full     = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= 32'd0;
      in_frame_r <= 1'b0;
      byte_cnt_r <= 9'd0;
      len_r      <= 8'd0;
      sum_r      <= 8'd0;
      asm_r      <= 32'd0;
      lane_r     <= 2'd0;
      ptr_r      <= 7'd0;
      idle_r     <= 16'd0;
      full_r     <= 1'b0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        hdr_r[i] <= 8'd0;
      end
    end else if (step_en) begin
      shift_r    <= shift_nxt;
      in_frame_r <= in_frame_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      asm_r      <= asm_nxt;
      lane_r     <= lane_nxt;
      ptr_r      <= ptr_nxt;
      idle_r     <= idle_nxt;
      full_r     <= full_nxt;
      hdr_r      <= hdr_nxt;
    end
  end

endmodule

// File: rtl/core/ft12_frame_receiver.sv
// ============================================================================
// ft12_frame_receiver
// FT1.2 variable-length frame receiver, one transaction per cycle while the result queue has room.
// ============================================================================
// Input channel (in_valid/in_stall/in_data): one transaction per received
// byte, idle tick or buffer release. Every accepted transaction yields
// exactly one result on the output channel (out_valid/out_stall/out_data):
// an optional buffer word to write, the frame-good strobe, the captured
// header fields and the buffer-full flag.
// Path: the input register, then the step logic into a two-entry result
// queue; out_valid rises once a result has been pushed into that queue.
// Throughput: one transaction per cycle while the result queue is not full;
// the receive core updates its state once for each accepted transaction.
// Reset (rst_n low at a clock edge) clears all frame state, empties the
// pipeline and reloads start 0x68, end 0x16 and idle limit 100.
// When the downstream side stalls, the queue absorbs two results and the
// input register one more transaction; after that in_stall rises.
// Configuration writes (cfg_wen, cfg_index, cfg_wdata) take effect at the
// next edge and are meant for idle periods only.
// ============================================================================
module ft12_frame_receiver
  import ft12_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic      in_valid_r;
  in_item_t  in_data_r;
  cfg_regs_t cfg_r;
  logic      q_full;
  logic      step_en;
  out_item_t step_result;

  assign in_stall = in_valid_r && q_full;
  assign step_en  = in_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char <= START_CHAR_RST;
      cfg_r.stop_char  <= STOP_CHAR_RST;
      cfg_r.idle_limit <= IDLE_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_START_CHAR: cfg_r.start_char <= cfg_wdata[7:0];
        CFG_STOP_CHAR:  cfg_r.stop_char  <= cfg_wdata[7:0];
        CFG_IDLE_LIMIT: cfg_r.idle_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ft12_rx_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  ft12_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_en),
    .push_data (step_result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/ft12_frame_receiver_checker.sv
// ============================================================================
// ft12_frame_receiver_checker
// Port-level checks for the FT1.2 receiver, bound to the top level.
// ============================================================================
`include "ft12_frame_receiver_assert.svh"

module ft12_frame_receiver_checker
  import ft12_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic good_seen;
  logic good_closed;

  assign good_seen   = out_valid && out_data.frame_good;
  assign good_closed = out_data.buffer_full && out_data.word_write;

  // a stalled result transaction holds
  `FT12_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // input backpressure only follows a downstream stall
  `FT12_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, $past(out_stall))

  // a good frame always carries its final word and raises buffer-full
  `FT12_ASSERT_SAME(a_good_full, clk, rst_n, good_seen, good_closed)

  // reset empties the result side
  `FT12_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind ft12_frame_receiver ft12_frame_receiver_checker u_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the FT1.2 variable-frame receiver. A cycle-level
// predictor follows every accepted transaction (bytes, idle ticks,
// releases). Each result is checked field by field against the oldest
// prediction. Stimulus starts with a short directed run and then moves to
// random frames (good, corrupted, truncated), noise, tick bursts and
// releases. It runs under three register settings and three stall profiles.
// ============================================================================
module tb_top;
  import ft12_pkg::*;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  ft12_frame_receiver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  in_item_t  line_traffic[$];
  out_item_t expected_reports[$];
  int        queued_items = 0;
  int        error_count = 0;
  int        shown_lines = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // receiver copy: registers and frame state
  logic [7:0]  rx_start_char = START_CHAR_RST;
  logic [7:0]  rx_stop_char  = STOP_CHAR_RST;
  logic [15:0] rx_idle_limit = IDLE_LIMIT_RST;
  logic [31:0] hunt_window = '0;
  logic        framing = 1'b0;
  logic [8:0]  frame_pos = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  chk_acc = '0;
  logic [31:0] word_acc = '0;
  logic [1:0]  lane = '0;
  logic [6:0]  word_ptr = '0;
  logic [15:0] idle_ticks = '0;
  logic        buf_full = 1'b0;
  logic [7:0]  hdr [HEADER_BYTES] = '{default: 8'h00};

  function automatic out_item_t frame_rx_step(in_item_t it);
    out_item_t  r;
    logic [8:0] n;
    logic [9:0] total;
    logic [16:0] next_idle;
    r = '0;
    case (it.kind)
      KIND_BYTE: begin
        // bytes are dropped entirely while a good frame awaits release
        if (!buf_full) begin
          idle_ticks = '0;
          if (!framing) begin
            hunt_window = {hunt_window[23:0], it.rx_byte};
            if (hunt_window[7:0] == rx_start_char && hunt_window[31:24] == rx_start_char &&
                hunt_window[15:8] == hunt_window[23:16]) begin
              frame_len     = hunt_window[15:8];
              framing       = 1'b1;
              frame_pos     = '0;
              chk_acc       = '0;
              r.word_write  = 1'b1;
              r.word_index  = '0;
              r.word_value  = {frame_len, frame_len, rx_start_char, 8'h00} & WORD0_MASK;
              word_acc      = {24'h0, rx_start_char};
              lane          = 2'd1;
              word_ptr      = 7'd1;
              hunt_window   = '0;
            end
          end else begin
            total     = {2'b00, frame_len} + 10'd2;
            n         = frame_pos + 9'd1;
            frame_pos = n;
            if (n <= frame_len)
              chk_acc = chk_acc + it.rx_byte;
            else if (n == {1'b0, frame_len} + 9'd1)
              chk_acc = chk_acc ^ it.rx_byte;
            if (n >= 1 && n <= HEADER_BYTES)
              hdr[4'(n - 9'd1)] = it.rx_byte;
            if (lane == 2'd0)
              word_acc = {24'h0, it.rx_byte};
            else
              word_acc = word_acc | ({24'h0, it.rx_byte} << (8 * lane));
            if (lane == 2'd3 || n >= total) begin
              r.word_write = 1'b1;
              r.word_index = word_ptr;
              r.word_value = word_acc;
            end
            if (lane == 2'd3) begin
              lane     = 2'd0;
              word_ptr = word_ptr + 7'd1;
            end else begin
              lane = lane + 2'd1;
            end
            if (n >= total) begin
              framing = 1'b0;
              if (chk_acc == 8'h00 && it.rx_byte == rx_stop_char) begin
                buf_full     = 1'b1;
                r.frame_good = 1'b1;
              end
            end
          end
        end
      end
      KIND_TICK: begin
        next_idle = {1'b0, idle_ticks} + 17'd1;
        if (next_idle > {1'b0, rx_idle_limit}) begin
          idle_ticks = '0;
          framing    = 1'b0;
        end else begin
          idle_ticks = next_idle[15:0];
        end
      end
      KIND_RELEASE: buf_full = 1'b0;
      default: ;
    endcase
    r.link_control    = hdr[0];
    r.dest_subaddress = hdr[1];
    r.message_type    = {hdr[3], hdr[2]};
    r.dest_address    = {hdr[5], hdr[4]};
    r.source_address  = {hdr[7], hdr[6]};
    r.hop_count       = hdr[8];
    r.sequence_number = {hdr[10], hdr[9]};
    r.buffer_full     = buf_full;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      // keep the log bounded when the design is badly off
      if (shown_lines < 200) begin
        shown_lines++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
    end
  endtask

  task automatic check_report(out_item_t want, out_item_t got);
    check_field("word_write",      32'(want.word_write),      32'(got.word_write));
    check_field("word_index",      32'(want.word_index),      32'(got.word_index));
    check_field("word_value",      want.word_value,           got.word_value);
    check_field("frame_good",      32'(want.frame_good),      32'(got.frame_good));
    check_field("link_control",    32'(want.link_control),    32'(got.link_control));
    check_field("dest_subaddress", 32'(want.dest_subaddress), 32'(got.dest_subaddress));
    check_field("message_type",    32'(want.message_type),    32'(got.message_type));
    check_field("dest_address",    32'(want.dest_address),    32'(got.dest_address));
    check_field("source_address",  32'(want.source_address),  32'(got.source_address));
    check_field("hop_count",       32'(want.hop_count),       32'(got.hop_count));
    check_field("sequence_number", 32'(want.sequence_number), 32'(got.sequence_number));
    check_field("buffer_full",     32'(want.buffer_full),     32'(got.buffer_full));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: a stalled transaction is held, otherwise the next one may go
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_reports.push_back(frame_rx_step(in_data));
      if (!in_valid || !in_stall) begin
        if (line_traffic.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= line_traffic.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          if (shown_lines < 200) begin
            shown_lines++;
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          end
        end else begin
          check_report(expected_reports.pop_front(), out_data);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(logic [1:0] k, logic [7:0] b);
    in_item_t x;
    x.kind    = k;
    x.rx_byte = b;
    line_traffic.push_back(x);
    queued_items++;
  endtask

  // flaw: 0 good, 1 bad checksum, 2 bad end, 3 cut short, 4 length mismatch
  task automatic push_frame(int len, int flaw);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = '0;
    push_item(KIND_BYTE, rx_start_char);
    push_item(KIND_BYTE, len[7:0]);
    push_item(KIND_BYTE, (flaw == 4) ? len[7:0] ^ 8'h01 : len[7:0]);
    push_item(KIND_BYTE, rx_start_char);
    for (i = 0; i < len; i++) begin
      b   = 8'($urandom_range(255));
      sum = sum + b;
      push_item(KIND_BYTE, b);
      if ($urandom_range(19) == 0)
        push_item(KIND_TICK, 8'($urandom_range(255)));
    end
    if (flaw != 3) begin
      push_item(KIND_BYTE, (flaw == 1) ? sum ^ (8'h01 << $urandom_range(7)) : sum);
      push_item(KIND_BYTE, (flaw == 2) ? rx_stop_char ^ (8'h01 << $urandom_range(7))
                                       : rx_stop_char);
    end
  endtask

  task automatic fill_random(int stop_at);
    int sel;
    int len;
    int flaw;
    int n;
    while (queued_items < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(25, 255) : $urandom_range(0, 24);
        n   = $urandom_range(99);
        flaw = (n < 70) ? 0 : (n < 78) ? 1 : (n < 86) ? 2 : (n < 93) ? 3 : 4;
        push_frame(len, flaw);
        if (flaw == 0 && $urandom_range(99) < 85)
          push_item(KIND_RELEASE, 8'($urandom_range(255)));
      end else if (sel < 80) begin
        for (n = $urandom_range(1, 6); n > 0; n--)
          push_item(KIND_BYTE,
                    ($urandom_range(3) == 0) ? rx_start_char : 8'($urandom_range(255)));
      end else if (sel < 90) begin
        for (n = $urandom_range(1, 5); n > 0; n--)
          push_item(KIND_TICK, 8'($urandom_range(255)));
      end else begin
        push_item(KIND_RELEASE, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (line_traffic.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_START_CHAR: rx_start_char = val[7:0];
      CFG_STOP_CHAR:  rx_stop_char  = val[7:0];
      CFG_IDLE_LIMIT: rx_idle_limit = val;
      default: ;
    endcase
  endtask

  initial begin
    int ph;
    int stop_at;
    send_idle_pct = 24;
    recv_idle_pct = 81;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, short frame, byte and tick while full,
    // unused kind, release twice, corrupted checksum
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_BYTE, 8'h00);
    push_frame(0, 0);
    push_item(KIND_BYTE, 8'h55);
    push_item(KIND_TICK, 8'hff);
    push_item(KIND_SPARE, 8'hff);
    push_item(KIND_RELEASE, 8'h00);
    push_item(KIND_RELEASE, 8'hff);
    push_frame(3, 1);
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_START_CHAR, 16'h0068);
          write_reg(CFG_STOP_CHAR,  16'h0016);
          write_reg(CFG_IDLE_LIMIT, 16'd3);
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 24;
          write_reg(CFG_START_CHAR, 16'h00ff);
          write_reg(CFG_STOP_CHAR,  16'h0000);
          write_reg(CFG_IDLE_LIMIT, 16'd1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(CFG_START_CHAR, 16'h0000);
          write_reg(CFG_STOP_CHAR,  16'h00ff);
          write_reg(CFG_IDLE_LIMIT, 16'hffff);
          push_frame(255, 0);
          push_item(KIND_RELEASE, 8'h00);
        end
      endcase
      stop_at = queued_items + 190;
      fill_random(stop_at - 95);
      // hold the sender until the receiver has caught up
      wait_drained();
      fill_random(stop_at);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
